### rtl/winding_number_point_in_polygon_macros.svh
// Assertion macros for the winding-number point-in-polygon block.
// Uses the clock and reset names of the module that includes this header.
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_MACROS_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define WNPIP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("winding number check failed");
// Next-cycle implication.
`define WNPIP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("winding number check failed");
`else
`define WNPIP_ASSERT_IMPLY(label, ante, cons)
`define WNPIP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/wnpip_pkg.sv
// Shared types and constants for the winding-number point-in-polygon block.
// No dependencies.
package wnpip_pkg;

   localparam int MAX_VERTICES_DEF = 256;
   localparam int COORD_W          = 32;
   localparam int DIFF_W           = COORD_W + 1;   // coordinate difference, signed
   localparam int MAG_W            = COORD_W;       // magnitude of a difference
   localparam int DIG_W            = 16;            // multiplier digit per cell
   localparam int N_CELLS          = MAG_W / DIG_W;
   localparam int PROD_W           = 2 * MAG_W;
   localparam int COUNT_W          = 9;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
   localparam logic [0:0] REG_CLOSED_LOOP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // One edge travelling down the multiplier chain.
   typedef struct packed {
      logic              valid;
      logic              up;
      logic              down;
      logic              neg1;
      logic              neg2;
      logic [MAG_W-1:0]  a1;
      logic [MAG_W-1:0]  b1;
      logic [MAG_W-1:0]  a2;
      logic [MAG_W-1:0]  b2;
      logic [PROD_W-1:0] acc1;
      logic [PROD_W-1:0] acc2;
   } cell_type;

endpackage

### rtl/wnpip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wnpip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wnpip_edge.sv
// Edge set-up stage: differences, magnitudes, signs and crossing flags.
// Depends on wnpip_pkg.
module wnpip_edge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic signed [wnpip_pkg::COORD_W-1:0] x0,
   input  logic signed [wnpip_pkg::COORD_W-1:0] y0,
   input  logic signed [wnpip_pkg::COORD_W-1:0] x1,
   input  logic signed [wnpip_pkg::COORD_W-1:0] y1,
   input  logic signed [wnpip_pkg::COORD_W-1:0] px,
   input  logic signed [wnpip_pkg::COORD_W-1:0] py,
   output wnpip_pkg::cell_type                  cell_out
);

   localparam int DIFF_W = wnpip_pkg::DIFF_W;
   localparam int MAG_W  = wnpip_pkg::MAG_W;

   function automatic logic [MAG_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] d);
      logic signed [DIFF_W-1:0] n;
      n = -d;
      return d[DIFF_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
   endfunction

   logic signed [DIFF_W-1:0] dx, dyp, dxp, dy;
   wnpip_pkg::cell_type      cell_in, cell_ff;

   assign dx  = DIFF_W'(x1) - DIFF_W'(x0);
   assign dyp = DIFF_W'(py) - DIFF_W'(y0);
   assign dxp = DIFF_W'(px) - DIFF_W'(x0);
   assign dy  = DIFF_W'(y1) - DIFF_W'(y0);

   always_comb begin
      cell_in.valid = in_valid;
      cell_in.up    = (y0 <= py) && (y1 > py);
      cell_in.down  = (y0 > py) && (y1 <= py);
      cell_in.neg1  = dx[DIFF_W-1] ^ dyp[DIFF_W-1];
      cell_in.neg2  = dxp[DIFF_W-1] ^ dy[DIFF_W-1];
      cell_in.a1    = diff_mag(dx);
      cell_in.b1    = diff_mag(dyp);
      cell_in.a2    = diff_mag(dxp);
      cell_in.b2    = diff_mag(dy);
      cell_in.acc1  = '0;
      cell_in.acc2  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

### rtl/wnpip_cell.sv
// One multiplier cell: folds the top digit of each multiplier into its product.
// Depends on wnpip_pkg.
module wnpip_cell (
   input  logic                clock,
   input  logic                reset,
   input  wnpip_pkg::cell_type cell_in,
   output wnpip_pkg::cell_type cell_out
);

   localparam int MAG_W  = wnpip_pkg::MAG_W;
   localparam int DIG_W  = wnpip_pkg::DIG_W;
   localparam int PROD_W = wnpip_pkg::PROD_W;

   logic [DIG_W-1:0]       dig1, dig2;
   logic [MAG_W+DIG_W-1:0] pp1, pp2;
   wnpip_pkg::cell_type    next_in, cell_ff;

   assign dig1 = cell_in.b1[MAG_W-1 -: DIG_W];
   assign dig2 = cell_in.b2[MAG_W-1 -: DIG_W];
   assign pp1  = cell_in.a1 * dig1;
   assign pp2  = cell_in.a2 * dig2;

   always_comb begin
      next_in      = cell_in;
      // shift the partial product up one digit, add this digit's product
      next_in.acc1 = (cell_in.acc1 << DIG_W) + PROD_W'(pp1);
      next_in.acc2 = (cell_in.acc2 << DIG_W) + PROD_W'(pp2);
      // advance the next digit to the top
      next_in.b1   = cell_in.b1 << DIG_W;
      next_in.b2   = cell_in.b2 << DIG_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= next_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

### rtl/winding_number_point_in_polygon.sv
// Winding-number point-in-polygon tester, top level.
// A vertex write is stored on acceptance. A query walks the vertex store, one read per
// cycle, drains the multiplier chain and then loads the result; no new word is accepted
// until the result is loaded. An empty or open polygon answers without a walk.
// Synchronous reset clears control.
// Depends on wnpip_pkg, wnpip_ram, wnpip_edge, wnpip_cell and the macros header.
`include "winding_number_point_in_polygon_macros.svh"

module winding_number_point_in_polygon #(
   parameter int MAX_VERTICES = wnpip_pkg::MAX_VERTICES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input word
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [7:0]                           req_vertex_index,
   input  logic signed [wnpip_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [wnpip_pkg::COORD_W-1:0] req_coord_y,
   // result word
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_inside_res,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int COORD_W = wnpip_pkg::COORD_W;
   localparam int COUNT_W = wnpip_pkg::COUNT_W;
   localparam int N_CELLS = wnpip_pkg::N_CELLS;
   localparam int AW      = $clog2(MAX_VERTICES);
   localparam int WN_W    = $clog2(MAX_VERTICES + 1) + 1;

   // ---------------------------------------------------------------------------
   // Register port: vertex_count at byte 0, closed_loop at byte 4.
   // Writes are taken on the access cycle; pready is tied high.
   // ---------------------------------------------------------------------------
   logic               cfg_wr;
   logic [COUNT_W-1:0] cfg_count_ff, cfg_count_in;
   logic               cfg_closed_ff, cfg_closed_in;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_count_in  = cfg_count_ff;
      cfg_closed_in = cfg_closed_ff;
      if (cfg_wr) begin
         case (paddr[2])
            wnpip_pkg::REG_VERTEX_COUNT: cfg_count_in  = pwdata[COUNT_W-1:0];
            wnpip_pkg::REG_CLOSED_LOOP:  cfg_closed_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         wnpip_pkg::REG_VERTEX_COUNT: prdata = 32'(cfg_count_ff);
         wnpip_pkg::REG_CLOSED_LOOP:  prdata = 32'(cfg_closed_ff);
         default:                     prdata = '0;
      endcase
   end

   // Saturate the vertex count at the size of the store.
   logic [COUNT_W-1:0] n_eff;
   assign n_eff = (32'(cfg_count_ff) > MAX_VERTICES) ? COUNT_W'(MAX_VERTICES) : cfg_count_ff;

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   wnpip_pkg::state_type state_ff, state_in;
   logic                 req_fire, query_start, vtx_write, rd_en, rsp_load, pipe_busy;
   logic [COUNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [COUNT_W-1:0]   n_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic                 trivial;

   assign req_fire    = req_valid && req_ready;
   assign query_start = req_fire && (req_action == wnpip_pkg::ACT_QUERY);
   assign vtx_write   = req_fire && (req_action == wnpip_pkg::ACT_WRITE)
                        && (32'(req_vertex_index) < MAX_VERTICES);
   // An empty polygon or an open strip answers outside without a walk.
   assign trivial     = (n_eff == '0) || !cfg_closed_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wnpip_pkg::ST_IDLE: begin
            if (query_start) begin
               state_in = trivial ? wnpip_pkg::ST_FINISH : wnpip_pkg::ST_WALK;
            end
         end
         wnpip_pkg::ST_WALK: begin
            // the last read fetches vertex zero again to close the polygon
            if (rd_idx_ff == n_ff) begin
               state_in = wnpip_pkg::ST_DRAIN;
            end
         end
         wnpip_pkg::ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = wnpip_pkg::ST_FINISH;
            end
         end
         wnpip_pkg::ST_FINISH: begin
            if (!rsp_valid || rsp_ready) begin
               state_in = wnpip_pkg::ST_IDLE;
            end
         end
         default: state_in = wnpip_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         wnpip_pkg::ST_IDLE:   req_ready = 1'b1;
         wnpip_pkg::ST_WALK:   rd_en     = 1'b1;
         wnpip_pkg::ST_DRAIN:  ;
         wnpip_pkg::ST_FINISH: rsp_load  = !rsp_valid || rsp_ready;
         default: ;
      endcase
   end

   assign rd_idx_in = (state_ff == wnpip_pkg::ST_WALK) ? rd_idx_ff + COUNT_W'(1) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wnpip_pkg::ST_IDLE;
         rd_idx_ff     <= '0;
         cfg_count_ff  <= '0;
         cfg_closed_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_closed_ff <= cfg_closed_in;
      end
   end

   // hold the query point and the edge count for the whole walk
   always_ff @(posedge clock) begin
      if (query_start) begin
         n_ff  <= n_eff;
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
   end

   // ---------------------------------------------------------------------------
   // Vertex store: one RAM per coordinate, written by vertex words, read once
   // per walk cycle. Vertex n wraps back to vertex zero.
   // ---------------------------------------------------------------------------
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [COORD_W-1:0] ram_x, ram_y;

   assign wr_addr = AW'(req_vertex_index);
   assign rd_addr = (rd_idx_ff == n_ff) ? '0 : AW'(rd_idx_ff);

   wnpip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_x (
      .clock   (clock),
      .wr_en   (vtx_write),
      .wr_addr (wr_addr),
      .wr_data (req_coord_x),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_x)
   );

   wnpip_ram #(.WIDTH(COORD_W), .DEPTH(MAX_VERTICES)) u_ram_y (
      .clock   (clock),
      .wr_en   (vtx_write),
      .wr_addr (wr_addr),
      .wr_data (req_coord_y),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_y)
   );

   // read data arrives in the cycle after the address; the first vertex only
   // primes the previous-vertex register
   logic rd_vld_ff, rd_edge_ff;
   logic signed [COORD_W-1:0] prev_x_ff, prev_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         rd_edge_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_en;
         rd_edge_ff <= rd_en && (rd_idx_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prev_x_ff <= ram_x;
         prev_y_ff <= ram_y;
      end
   end

   // ---------------------------------------------------------------------------
   // Edge set-up, then a chain of identical multiplier cells. Each cell folds
   // one 16-bit digit of both cross-product multipliers into the running
   // products and hands the edge on to its neighbour every cycle.
   // ---------------------------------------------------------------------------
   wnpip_pkg::cell_type chain [N_CELLS+1];

   wnpip_edge u_edge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rd_vld_ff && rd_edge_ff),
      .x0       (prev_x_ff),
      .y0       (prev_y_ff),
      .x1       ($signed(ram_x)),
      .y1       ($signed(ram_y)),
      .px       (px_ff),
      .py       (py_ff),
      .cell_out (chain[0])
   );

   for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
      wnpip_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   always_comb begin
      pipe_busy = rd_vld_ff;
      for (int k = 0; k <= N_CELLS; k++) begin
         pipe_busy = pipe_busy || chain[k].valid;
      end
   end

   // ---------------------------------------------------------------------------
   // Side test and winding count. The cross product is compared as sign and
   // magnitude; a zero product counts as non-negative.
   // ---------------------------------------------------------------------------
   wnpip_pkg::cell_type last;
   logic n1, n2, mag_eq, mag_gt, side_pos, side_neg;
   logic signed [WN_W-1:0] wn_ff, wn_in;

   assign last   = chain[N_CELLS];
   assign n1     = last.neg1 && (last.acc1 != '0);
   assign n2     = last.neg2 && (last.acc2 != '0);
   assign mag_eq = last.acc1 == last.acc2;
   assign mag_gt = last.acc1 > last.acc2;

   always_comb begin
      if (n1 != n2) begin
         side_pos = n2;
         side_neg = n1;
      end else begin
         side_pos = !mag_eq && (n1 ? !mag_gt : mag_gt);
         side_neg = !mag_eq && (n1 ? mag_gt : !mag_gt);
      end
   end

   always_comb begin
      wn_in = wn_ff;
      if (query_start) begin
         wn_in = '0;
      end else if (last.valid) begin
         // upward crossing with the point on or left of the edge
         if (last.up && !side_neg) begin
            wn_in = wn_ff + WN_W'(1);
         // downward crossing with the point on or right of the edge
         end else if (last.down && !side_pos) begin
            wn_in = wn_ff - WN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wn_ff <= '0;
      end else begin
         wn_ff <= wn_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result register: hold the answer until the word is taken.
   // ---------------------------------------------------------------------------
   logic rsp_valid_ff, rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_inside_ff <= (wn_ff != '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `WNPIP_ASSERT_IMPLY(a_idle_pipe_empty, state_ff == wnpip_pkg::ST_IDLE, !pipe_busy)
   `WNPIP_ASSERT_IMPLY(a_walk_index, state_ff == wnpip_pkg::ST_WALK, rd_idx_ff <= n_ff)
   `WNPIP_ASSERT_NEXT(a_query_start, query_start, state_ff == wnpip_pkg::ST_WALK || state_ff == wnpip_pkg::ST_FINISH)
   `WNPIP_ASSERT_NEXT(a_trivial_outside, query_start && trivial, wn_ff == '0 && !pipe_busy)

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the winding-number point-in-polygon block.
// Loads polygons, asks point queries and compares each inside flag with a local
// predictor. Depends on wnpip_pkg and winding_number_point_in_polygon.

module tb_top;

   localparam int MAX_VERTS = wnpip_pkg::MAX_VERTICES_DEF;

   // One input word as the sender sees it.
   typedef struct {
      logic               action;
      logic [7:0]         slot;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } poly_word_type;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_vertex_index = 8'd0;
   logic signed [31:0] req_coord_x = 32'sd0;
   logic signed [31:0] req_coord_y = 32'sd0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_inside_res;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Words waiting for the driver, and inside flags waiting for the monitor.
   poly_word_type pending_words[$];
   logic          expected_inside[$];
   int            mismatch_count = 0;
   int            items_made = 0;

   // Predictor state: vertex store and register copies, updated on acceptance.
   logic signed [31:0] corner_x [MAX_VERTS];
   logic signed [31:0] corner_y [MAX_VERTS];
   logic [8:0]         cfg_count = 9'd0;
   logic               cfg_closed = 1'b1;

   // Stimulus side view of the polygon, used to aim queries at vertices and edges.
   logic signed [31:0] plan_x [MAX_VERTS];
   logic signed [31:0] plan_y [MAX_VERTS];
   int                 shape_style = 0;
   int                 shape_cx = 0;
   int                 shape_cy = 0;
   int unsigned        shape_r = 1024;

   // Sender and receiver pacing.
   logic        req_taken = 1'b0;
   int          burst_left = 0;
   int          gap_left = 0;
   logic [15:0] ready_pattern = 16'hffff;
   int          pattern_pos = 0;
   int          hold_left = 0;
   bit          want_long_hold = 1'b0;

   winding_number_point_in_polygon DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

   // Print one line per mismatch and count it.
   task automatic flag_error(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Winding count over the stored polygon. Cross products are formed at full
   // width: each difference needs 33 bits, each product up to 66.
   function automatic logic winding_inside(logic signed [31:0] px, logic signed [31:0] py);
      int unsigned        n;
      int unsigned        j;
      int                 wn;
      logic signed [31:0] x0, y0, x1, y1;
      logic signed [32:0] ex, ey, qx, qy;
      logic signed [67:0] lhs, rhs;
      wn = 0;
      n = 32'(cfg_count);
      if (!cfg_closed || n == 0)
         return 1'b0;
      // counts beyond the store saturate
      if (n > MAX_VERTS)
         n = MAX_VERTS;
      for (int unsigned i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         x0 = corner_x[i];
         y0 = corner_y[i];
         x1 = corner_x[j];
         y1 = corner_y[j];
         ex = x1 - x0;
         ey = y1 - y0;
         qx = px - x0;
         qy = py - y0;
         // lhs - rhs > 0: point left of the edge, < 0: right, 0: on the line
         lhs = ex * qy;
         rhs = qx * ey;
         if (y0 <= py) begin
            if (y1 > py && lhs >= rhs)
               wn++;
         end else if (y1 <= py && lhs <= rhs) begin
            wn--;
         end
      end
      return (wn != 0);
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: present pending words in bursts, hold each word until it is taken.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      poly_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_valid        <= 1'b1;
            req_action       <= w.action;
            req_vertex_index <= w.slot;
            req_coord_x      <= w.x;
            req_coord_y      <= w.y;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // occasionally a long unbroken run, otherwise short bursts
               burst_left = ($urandom_range(3) == 0) ? 80 : $urandom_range(1, 24);
               gap_left   = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall on a rolling 16-bit pattern; honour one long hold-off.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (want_long_hold) begin
            want_long_hold = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ready_pattern[pattern_pos];
            if (pattern_pos == 15) begin
               pattern_pos = 0;
               case ($urandom_range(3))
                  0:       ready_pattern = 16'hffff;
                  1:       ready_pattern = 16'($urandom | $urandom);
                  2:       ready_pattern = 16'($urandom);
                  default: ready_pattern = 16'($urandom & $urandom);
               endcase
            end else begin
               pattern_pos++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge; check results, then
   // advance the predictor with any word accepted at this edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      logic want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_inside.size() == 0) begin
            flag_error("result word arrived with nothing expected");
         end else begin
            want = expected_inside.pop_front();
            if (rsp_inside_res !== want)
               flag_error($sformatf("inside_res got %b, want %b", rsp_inside_res, want));
         end
      end
      if (!reset && req_valid && req_ready) begin
         if (req_action == wnpip_pkg::ACT_WRITE) begin
            corner_x[req_vertex_index] = req_coord_x;
            corner_y[req_vertex_index] = req_coord_y;
         end else begin
            expected_inside = {expected_inside, winding_inside(req_coord_x, req_coord_y)};
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_vertex(input int unsigned slot, input logic signed [31:0] x,
                              input logic signed [31:0] y);
      poly_word_type w;
      w.action = wnpip_pkg::ACT_WRITE;
      w.slot   = slot[7:0];
      w.x      = x;
      w.y      = y;
      plan_x[slot[7:0]] = x;
      plan_y[slot[7:0]] = y;
      pending_words = {pending_words, w};
      items_made++;
   endtask

   task automatic push_query(input logic signed [31:0] x, input logic signed [31:0] y);
      poly_word_type w;
      w.action = wnpip_pkg::ACT_QUERY;
      w.slot   = 8'($urandom);   // ignored by the block, toggled anyway
      w.x      = x;
      w.y      = y;
      pending_words = {pending_words, w};
      items_made++;
   endtask

   function automatic int jitter(int unsigned r);
      return int'(longint'($urandom_range(2 * r)) - longint'(r));
   endfunction

   function automatic logic signed [31:0] extreme_coord();
      case ($urandom_range(3))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic logic signed [31:0] shape_coord(int centre);
      case (shape_style)
         0:       return centre + jitter(shape_r);
         1:       return $urandom;
         default: return ($urandom_range(1) == 0) ? extreme_coord() : $urandom;
      endcase
   endfunction

   // Aim a query near the shape, at a vertex, on an edge midpoint, on a vertex
   // row, or anywhere at all.
   task automatic pick_point(input int unsigned n_eff, output logic signed [31:0] px,
                             output logic signed [31:0] py);
      int unsigned        k, m, kind;
      logic signed [32:0] sx, sy;
      k = (n_eff > 0) ? $urandom_range(n_eff - 1) : 0;
      m = (k + 1 == n_eff) ? 0 : k + 1;
      kind = $urandom_range(7);
      if (n_eff == 0 && kind inside {3, 4, 5})
         kind = 0;
      case (kind)
         3: begin
            px = plan_x[k];
            py = plan_y[k];
         end
         4: begin
            sx = {plan_x[k][31], plan_x[k]} + {plan_x[m][31], plan_x[m]};
            sy = {plan_y[k][31], plan_y[k]} + {plan_y[m][31], plan_y[m]};
            px = sx[32:1];
            py = sy[32:1];
         end
         5: begin
            px = shape_cx + jitter(shape_r + shape_r / 4);
            py = plan_y[k];
         end
         6: begin
            px = $urandom;
            py = $urandom;
         end
         7: begin
            px = extreme_coord();
            py = extreme_coord();
         end
         default: begin
            px = shape_cx + jitter(shape_r + shape_r / 4);
            py = shape_cy + jitter(shape_r + shape_r / 4);
         end
      endcase
   endtask

   // Wait until every word is taken and every result has come back, then let
   // a trailing vertex write settle. Sample at the rising edge, where the
   // driver's queue and valid are both stable.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_words.size() > 0 || req_valid || expected_inside.size() > 0);
      repeat (8) @(negedge clock);
   endtask

   // One register transfer: setup cycle, access cycle, sample at completion.
   task automatic csr_access(input logic is_write, input logic [0:0] reg_id,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {reg_id, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Reprogram both registers once the block is idle, and read them back.
   // Upper data bits carry noise that the block must drop.
   task automatic set_registers(input logic [8:0] count, input logic closed);
      logic [31:0] wd, rd;
      wait_drained();
      wd = $urandom;
      wd[8:0] = count;
      csr_access(1'b1, wnpip_pkg::REG_VERTEX_COUNT, wd, rd);
      cfg_count = count;
      csr_access(1'b0, wnpip_pkg::REG_VERTEX_COUNT, 32'd0, rd);
      if (rd[8:0] !== count)
         flag_error($sformatf("vertex_count read %0d, want %0d", rd[8:0], count));
      wd = $urandom;
      wd[0] = closed;
      csr_access(1'b1, wnpip_pkg::REG_CLOSED_LOOP, wd, rd);
      cfg_closed = closed;
      csr_access(1'b0, wnpip_pkg::REG_CLOSED_LOOP, 32'd0, rd);
      if (rd[0] !== closed)
         flag_error($sformatf("closed_loop read %b, want %b", rd[0], closed));
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence: reset, directed corners, then random phases.
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned        n, n_eff, rot, sel, count_q, phase;
      logic               closed;
      bit                 full_loaded;
      logic signed [31:0] px, py;

      full_loaded = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Empty polygon straight out of reset: always outside.
      push_query(32'h8000_0000, 32'h8000_0000);
      push_query(32'h7fff_ffff, 32'h7fff_ffff);
      // Load a square and an extreme vertex far up the store.
      push_vertex(0, -1024, -1024);
      push_vertex(1,  1024, -1024);
      push_vertex(2,  1024,  1024);
      push_vertex(3, -1024,  1024);
      push_vertex(255, 32'h8000_0000, 32'h7fff_ffff);

      // Square: centre, three of its sides, a corner, far points of the range.
      set_registers(9'd4, 1'b1);
      push_query(0, 0);
      push_query(-1024, 0);
      push_query(1024, 0);
      push_query(0, 1024);
      push_query(-1024, -1024);
      push_query(32'h7fff_ffff, 32'h8000_0000);
      push_query(32'h8000_0000, 0);

      // Open strip answers outside even at the centre.
      set_registers(9'd4, 1'b0);
      push_query(0, 0);

      // One vertex, then two: degenerate edges still walked.
      set_registers(9'd1, 1'b1);
      push_query(-1024, -1024);
      push_query(0, 0);
      set_registers(9'd2, 1'b1);
      push_query(0, -1024);
      push_query(1024, -1024);

      // Random phases: mostly small well-formed polygons with aimed queries,
      // a few store-sized ones, and noise writes scattered through.
      phase = 0;
      while (items_made < 1300) begin
         sel = $urandom_range(99);
         closed = ($urandom_range(9) < 8);
         case (phase)
            2:       n = MAX_VERTS;
            3:       n = 4;
            5:       n = 511;
            8:       n = $urandom_range(MAX_VERTS + 1, 510);
            default: n = (sel < 5)  ? 0 :
                         (sel < 15) ? $urandom_range(1, 2) :
                         (sel < 80) ? $urandom_range(3, 12) : $urandom_range(13, 48);
         endcase
         if (phase == 3 || phase == 5)
            closed = 1'b1;
         n_eff = (n > MAX_VERTS) ? MAX_VERTS : n;

         sel = $urandom_range(99);
         shape_style = (sel < 70) ? 0 : (sel < 85) ? 1 : 2;
         if (shape_style == 0) begin
            shape_cx = jitter(32'h4000_0000);
            shape_cy = jitter(32'h4000_0000);
            shape_r  = 1 << $urandom_range(2, 20);
         end else begin
            shape_cx = 0;
            shape_cy = 0;
            shape_r  = 32'h4000_0000;
         end

         set_registers(n[8:0], closed);

         // Load every vertex in use before any query reads it.
         if (n_eff > 64) begin
            if (!full_loaded) begin
               for (int unsigned i = 0; i < MAX_VERTS; i++)
                  push_vertex(i, shape_coord(shape_cx), shape_coord(shape_cy));
               full_loaded = 1'b1;
            end else begin
               repeat (8)
                  push_vertex($urandom_range(MAX_VERTS - 1), shape_coord(shape_cx),
                              shape_coord(shape_cy));
            end
            count_q = 10;
         end else begin
            rot = (n_eff > 0) ? $urandom_range(n_eff - 1) : 0;
            for (int unsigned i = 0; i < n_eff; i++)
               push_vertex((i + rot) % n_eff, shape_coord(shape_cx), shape_coord(shape_cy));
            count_q = (phase == 3) ? 60 : $urandom_range(15, 45);
         end

         for (int unsigned q = 0; q < count_q; q++) begin
            sel = $urandom_range(99);
            if (sel < 70 || (phase == 3)) begin
               pick_point(n_eff, px, py);
               push_query(px, py);
            end else if (sel < 85 && n_eff > 0) begin
               // move one vertex of the live polygon
               push_vertex($urandom_range(n_eff - 1), shape_coord(shape_cx),
                           shape_coord(shape_cy));
            end else begin
               push_vertex($urandom_range(MAX_VERTS - 1), $urandom, $urandom);
            end
         end

         // Starve the result side for a long stretch so the block backs up.
         if (phase == 3) begin
            @(posedge clock);
            want_long_hold = 1'b1;
         end
         phase++;
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
